### rtl/sphere_vertex_generator_core_defines.svh
// ----------------------------------------------------------------------------
// Sphere vertex generator assertion macros
// Immediate-implication and next-cycle-implication property wrappers.
// ----------------------------------------------------------------------------
`ifndef SPHERE_VERTEX_GENERATOR_CORE_DEFINES_SVH
`define SPHERE_VERTEX_GENERATOR_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define SVG_ASSERT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sphere vertex generator assertion failed");
`define SVG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sphere vertex generator assertion failed");
`else
`define SVG_ASSERT(label, clk, rst_n, ante, cons)
`define SVG_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/svg_pkg.sv
// ----------------------------------------------------------------------------
// Sphere vertex generator package
// Payload types, register codes and fixed-point constants shared by the core.
// ----------------------------------------------------------------------------
package svg_pkg;

	localparam int unsigned MAX_RINGS    = 255;
	localparam int unsigned MAX_SEGMENTS = 256;
	localparam int unsigned MIN_RINGS    = 2;
	localparam int unsigned MIN_SEGMENTS = 3;

	localparam logic [7:0] RING_COUNT_RESET    = 8'd16;
	localparam logic [8:0] SEGMENT_COUNT_RESET = 9'd32;

	localparam int unsigned ADDR_W = 3;
	localparam logic ADDR_RING_COUNT    = 1'b0;
	localparam logic ADDR_SEGMENT_COUNT = 1'b1;

	// long division: four quotient bits per stage, 32 bits in all
	localparam int DIV_STAGES     = 8;
	localparam int DIV_STEPS      = 4;
	localparam int DIV_ROUND_SRC  = 4;

	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] Q30_ONE     = 31'h4000_0000;

	// sine/cosine pipeline: x, x^2, five Horner steps of three stages, final
	localparam int HORNER_STEPS = 5;
	localparam int SC_REGS      = 2 + 3 * HORNER_STEPS;
	localparam int SC_STAGES    = SC_REGS + 1;

	localparam logic [7:0] HORNER_DIV [2][HORNER_STEPS] = '{
		'{8'd110, 8'd72, 8'd42, 8'd20, 8'd6},
		'{8'd132, 8'd90, 8'd56, 8'd30, 8'd12}
	};
	localparam logic [31:0] HORNER_RECIP [2][HORNER_STEPS] = '{
		'{32'((64'd1 << 32) / 64'd110), 32'((64'd1 << 32) / 64'd72),
		  32'((64'd1 << 32) / 64'd42), 32'((64'd1 << 32) / 64'd20),
		  32'((64'd1 << 32) / 64'd6)},
		'{32'((64'd1 << 32) / 64'd132), 32'((64'd1 << 32) / 64'd90),
		  32'((64'd1 << 32) / 64'd56), 32'((64'd1 << 32) / 64'd30),
		  32'((64'd1 << 32) / 64'd12)}
	};

	typedef struct packed {
		logic [7:0] ring_index;
		logic [7:0] segment_index;
	} idx_t;

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic [16:0]        tex_u;
		logic [16:0]        tex_v;
		logic               index_valid;
	} vert_t;

	typedef struct packed {
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic        index_valid;
	} side_t;

	typedef struct packed {
		logic [31:0] sin_mag;
		logic        sin_neg;
		logic [31:0] cos_mag;
		logic        cos_neg;
	} trig_t;

endpackage

### rtl/svg_divider.sv
// ----------------------------------------------------------------------------
// Sphere vertex generator index divider
// Clamps the indices and runs a pipelined long division that yields the
// polar and azimuth phases and the rounded texture coordinates.
// ----------------------------------------------------------------------------
`include "sphere_vertex_generator_core_defines.svh"

module svg_divider (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  svg_pkg::idx_t       idx,
	input  logic [7:0]          rings,
	input  logic [8:0]          segs,
	output logic                vld_out,
	output logic [31:0]         polar,
	output logic [31:0]         azim,
	output svg_pkg::side_t      side
);

	typedef struct packed {
		logic [7:0]  rem_r;
		logic [7:0]  rem_s;
		logic [31:0] quo_r;
		logic [31:0] quo_s;
		logic        whole_r;
		logic [16:0] tex_u;
		logic [16:0] tex_v;
		logic        ok;
	} dstage_t;

	typedef struct packed {
		logic [7:0] rem;
		logic       qbit;
	} dstep_t;

	function automatic dstep_t div_step(input logic [7:0] rem, input logic [8:0] dvsr);
		logic [8:0] sh;
		dstep_t     res;
		sh       = {rem, 1'b0};
		res.qbit = (sh >= dvsr);
		res.rem  = res.qbit ? 8'(sh - dvsr) : sh[7:0];
		return res;
	endfunction

	dstage_t                          seed;
	dstage_t                          nxt   [svg_pkg::DIV_STAGES + 1];
	dstage_t                          div_s [svg_pkg::DIV_STAGES + 1];
	logic [svg_pkg::DIV_STAGES:0]     vld_s;
	logic [8:0]                       rings9;

	assign rings9 = {1'b0, rings};

	// clamp out-of-range indices and seed the remainders
	always_comb begin : clamp
		logic       ring_hi;
		logic       seg_hi;
		logic [7:0] ring_c;
		logic [7:0] seg_c;
		ring_hi = ({1'b0, idx.ring_index} > rings9);
		seg_hi  = ({1'b0, idx.segment_index} >= segs);
		ring_c  = ring_hi ? rings : idx.ring_index;
		seg_c   = seg_hi ? 8'(segs - 9'd1) : idx.segment_index;
		seed         = '0;
		seed.whole_r = (ring_c == rings);
		seed.rem_r   = seed.whole_r ? 8'd0 : ring_c;
		seed.rem_s   = seg_c;
		seed.ok      = !(ring_hi || seg_hi);
	end

	always_comb begin : divide
		dstep_t     sr;
		dstep_t     ss;
		logic [9:0] sum_r;
		logic [9:0] sum_s;
		sr     = '0;
		ss     = '0;
		sum_r  = '0;
		sum_s  = '0;
		nxt[0] = seed;
		for (int k = 1; k <= svg_pkg::DIV_STAGES; k++) begin
			nxt[k] = div_s[k-1];
			// sixteen fraction bits are in: round the texture coordinates
			if (k == svg_pkg::DIV_ROUND_SRC + 1) begin
				sum_r = 10'(div_s[k-1].rem_r) + 10'(rings[7:1]);
				sum_s = 10'(div_s[k-1].rem_s) + 10'(segs[8:1]);
				nxt[k].tex_v = {div_s[k-1].whole_r, div_s[k-1].quo_r[15:0]}
					+ 17'(sum_r >= 10'(rings9));
				nxt[k].tex_u = {1'b0, div_s[k-1].quo_s[15:0]}
					+ 17'(sum_s >= 10'(segs));
			end
			for (int j = 0; j < svg_pkg::DIV_STEPS; j++) begin
				sr = div_step(nxt[k].rem_r, rings9);
				ss = div_step(nxt[k].rem_s, segs);
				nxt[k].rem_r = sr.rem;
				nxt[k].rem_s = ss.rem;
				nxt[k].quo_r = {nxt[k].quo_r[30:0], sr.qbit};
				nxt[k].quo_s = {nxt[k].quo_s[30:0], ss.qbit};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[svg_pkg::DIV_STAGES-1:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k <= svg_pkg::DIV_STAGES; k++) begin
				div_s[k] <= nxt[k];
			end
		end
	end

	assign vld_out          = vld_s[svg_pkg::DIV_STAGES];
	assign polar            = {div_s[svg_pkg::DIV_STAGES].whole_r,
	                           div_s[svg_pkg::DIV_STAGES].quo_r[31:1]};
	assign azim             = div_s[svg_pkg::DIV_STAGES].quo_s;
	assign side.tex_u       = div_s[svg_pkg::DIV_STAGES].tex_u;
	assign side.tex_v       = div_s[svg_pkg::DIV_STAGES].tex_v;
	assign side.index_valid = div_s[svg_pkg::DIV_STAGES].ok;

	`SVG_ASSERT(a_polar_max_half_turn, clk, arst_n, vld_out && polar[31], polar[30:0] == 31'd0)
	`SVG_ASSERT(a_tex_u_below_one, clk, arst_n, vld_out, !side.tex_u[16])

endmodule

### rtl/svg_sincos.sv
// ----------------------------------------------------------------------------
// Sphere vertex generator sine/cosine unit
// Pipelined Q30 Taylor evaluation of sine and cosine of a 32-bit phase.
// ----------------------------------------------------------------------------
module svg_sincos (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  logic [31:0]         phase,
	output logic                vld_out,
	output svg_pkg::trig_t      trig
);

	typedef struct packed {
		logic [1:0]        quad;
		logic [30:0]       x;
		logic [31:0]       x2;
		logic [1:0][31:0]  prod;
		logic [1:0][31:0]  quo;
		logic [1:0][30:0]  t;
	} scstage_t;

	scstage_t                          nxt  [svg_pkg::SC_REGS];
	scstage_t                          st_s [svg_pkg::SC_REGS];
	svg_pkg::trig_t                    trig_nxt;
	svg_pkg::trig_t                    trig_s;
	logic [svg_pkg::SC_STAGES-1:0]     vld_s;

	// x and x^2 up front, then each Horner step: product, reciprocal
	// estimate, correct and subtract
	always_comb begin : horner
		logic [60:0] xprod;
		logic [61:0] sq;
		logic [62:0] hp;
		logic [63:0] rq;
		logic [39:0] qd;
		logic [39:0] rem;
		logic [32:0] q;
		int          step;
		int          ph;
		xprod         = 61'(phase[29:0]) * 61'(svg_pkg::HALF_PI_Q30);
		nxt[0]        = '0;
		nxt[0].quad   = phase[31:30];
		nxt[0].x      = xprod[60:30];
		nxt[0].t[0]   = svg_pkg::Q30_ONE;
		nxt[0].t[1]   = svg_pkg::Q30_ONE;
		nxt[1]        = st_s[0];
		sq            = 62'(st_s[0].x) * 62'(st_s[0].x);
		nxt[1].x2     = sq[61:30];
		hp  = '0;
		rq  = '0;
		qd  = '0;
		rem = '0;
		q   = '0;
		for (int k = 2; k < svg_pkg::SC_REGS; k++) begin
			step   = (k - 2) / 3;
			ph     = (k - 2) % 3;
			nxt[k] = st_s[k-1];
			for (int c = 0; c < 2; c++) begin
				if (ph == 0) begin
					hp = 63'(st_s[k-1].x2) * 63'(st_s[k-1].t[c]);
					nxt[k].prod[c] = hp[61:30];
				end else if (ph == 1) begin
					rq = 64'(st_s[k-1].prod[c]) * 64'(svg_pkg::HORNER_RECIP[c][step]);
					nxt[k].quo[c] = rq[63:32];
				end else begin
					qd  = 40'(st_s[k-1].quo[c]) * 40'(svg_pkg::HORNER_DIV[c][step]);
					rem = 40'(st_s[k-1].prod[c]) - qd;
					q   = 33'(st_s[k-1].quo[c])
						+ 33'(rem >= 40'(svg_pkg::HORNER_DIV[c][step]));
					nxt[k].t[c] = (q > 33'(svg_pkg::Q30_ONE)) ? 31'd0
						: 31'(33'(svg_pkg::Q30_ONE) - q);
				end
			end
		end
	end

	always_comb begin : finish
		logic [61:0] sp;
		logic [62:0] cp;
		logic [31:0] s;
		logic [31:0] pc;
		logic [31:0] c;
		scstage_t    cur;
		cur = st_s[svg_pkg::SC_REGS-1];
		sp  = 62'(cur.x) * 62'(cur.t[0]);
		s   = sp[61:30];
		cp  = 63'(cur.x2) * 63'(cur.t[1]);
		pc  = cp[62:31];
		c   = (pc > 32'(svg_pkg::Q30_ONE)) ? 32'd0 : 32'(svg_pkg::Q30_ONE) - pc;
		// fold the quadrant back by symmetry
		case (cur.quad)
			2'd0: trig_nxt = '{sin_mag: s, sin_neg: 1'b0, cos_mag: c, cos_neg: 1'b0};
			2'd1: trig_nxt = '{sin_mag: c, sin_neg: 1'b0, cos_mag: s, cos_neg: 1'b1};
			2'd2: trig_nxt = '{sin_mag: s, sin_neg: 1'b1, cos_mag: c, cos_neg: 1'b1};
			default: trig_nxt = '{sin_mag: c, sin_neg: 1'b1, cos_mag: s, cos_neg: 1'b0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[svg_pkg::SC_STAGES-2:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < svg_pkg::SC_REGS; k++) begin
				st_s[k] <= nxt[k];
			end
			trig_s <= trig_nxt;
		end
	end

	assign vld_out = vld_s[svg_pkg::SC_STAGES-1];
	assign trig    = trig_s;

endmodule

### rtl/svg_vertex.sv
// ----------------------------------------------------------------------------
// Sphere vertex generator vertex assembly
// Forms x, y, z from the trig results, rounds to Q15 and holds the result.
// ----------------------------------------------------------------------------
module svg_vertex (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                vld_in,
	input  svg_pkg::trig_t      polar_trig,
	input  svg_pkg::trig_t      azim_trig,
	input  svg_pkg::side_t      side,
	output logic                vld_out,
	output svg_pkg::vert_t      vert
);

	function automatic logic [15:0] half_to_q15(input logic [33:0] m, input logic neg);
		logic [34:0] r;
		logic [18:0] q;
		logic [14:0] sat;
		r   = 35'(m) + 35'd32768;
		q   = r[34:16];
		sat = (q > 19'd16384) ? 15'd16384 : q[14:0];
		return neg ? 16'(-{1'b0, sat}) : {1'b0, sat};
	endfunction

	logic [33:0]       mx_s1;
	logic [33:0]       mz_s1;
	logic [33:0]       my_s1;
	logic              nx_s1;
	logic              nz_s1;
	logic              ny_s1;
	svg_pkg::side_t    side_s1;
	svg_pkg::vert_t    vert_s2;
	logic [1:0]        vld_s;
	logic [63:0]       px;
	logic [63:0]       pz;

	assign px = 64'(polar_trig.sin_mag) * 64'(azim_trig.cos_mag);
	assign pz = 64'(polar_trig.sin_mag) * 64'(azim_trig.sin_mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mx_s1   <= px[63:30];
			mz_s1   <= pz[63:30];
			my_s1   <= 34'(polar_trig.cos_mag);
			nx_s1   <= polar_trig.sin_neg ^ azim_trig.cos_neg;
			nz_s1   <= polar_trig.sin_neg ^ azim_trig.sin_neg;
			ny_s1   <= polar_trig.cos_neg;
			side_s1 <= side;
			vert_s2.pos_x       <= half_to_q15(mx_s1, nx_s1);
			vert_s2.pos_y       <= half_to_q15(my_s1, ny_s1);
			vert_s2.pos_z       <= half_to_q15(mz_s1, nz_s1);
			vert_s2.tex_u       <= side_s1.tex_u;
			vert_s2.tex_v       <= side_s1.tex_v;
			vert_s2.index_valid <= side_s1.index_valid;
		end
	end

	assign vld_out = vld_s[1];
	assign vert    = vert_s2;

endmodule

### rtl/sphere_vertex_generator_core.sv
// Throughput: one index pair per cycle unless the output stalls; the pipeline
// from an accepted index pair to its vertex on vert_data is 29 register stages
// (9 for the long division, 18 for sine/cosine, 2 for vertex assembly).
// A stalled output freezes every stage and holds idx_stall high.
// Reset clears all valid bits and sets ring_count to 16, segment_count to 32.
// ----------------------------------------------------------------------------
// Sphere vertex generator core
// UV sphere vertex generation from ring and segment indices, APB config.
// ----------------------------------------------------------------------------
`include "sphere_vertex_generator_core_defines.svh"

module sphere_vertex_generator_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [svg_pkg::ADDR_W-1:0]     paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	input  logic                           idx_valid,
	output logic                           idx_stall,
	input  svg_pkg::idx_t                  idx_data,
	output logic                           vert_valid,
	input  logic                           vert_stall,
	output svg_pkg::vert_t                 vert_data
);

	logic [7:0]          ring_count_q;
	logic [8:0]          segment_count_q;
	logic                en;
	logic                cfg_wr;
	logic                div_vld;
	logic [31:0]         polar;
	logic [31:0]         azim;
	svg_pkg::side_t      div_side;
	svg_pkg::side_t      side_q [svg_pkg::SC_STAGES];
	logic                p_vld;
	logic                a_vld;
	svg_pkg::trig_t      p_trig;
	svg_pkg::trig_t      a_trig;
	logic [7:0]          ring_w;
	logic [8:0]          seg_w;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign ring_w = pwdata[7:0];
	assign seg_w  = pwdata[8:0];

	// clamp counts into their legal range on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ring_count_q    <= svg_pkg::RING_COUNT_RESET;
			segment_count_q <= svg_pkg::SEGMENT_COUNT_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				svg_pkg::ADDR_RING_COUNT: begin
					if (ring_w < 8'(svg_pkg::MIN_RINGS))
						ring_count_q <= 8'(svg_pkg::MIN_RINGS);
					else if (ring_w > 8'(svg_pkg::MAX_RINGS))
						ring_count_q <= 8'(svg_pkg::MAX_RINGS);
					else
						ring_count_q <= ring_w;
				end
				svg_pkg::ADDR_SEGMENT_COUNT: begin
					if (seg_w < 9'(svg_pkg::MIN_SEGMENTS))
						segment_count_q <= 9'(svg_pkg::MIN_SEGMENTS);
					else if (seg_w > 9'(svg_pkg::MAX_SEGMENTS))
						segment_count_q <= 9'(svg_pkg::MAX_SEGMENTS);
					else
						segment_count_q <= seg_w;
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			svg_pkg::ADDR_RING_COUNT:    prdata = 32'(ring_count_q);
			svg_pkg::ADDR_SEGMENT_COUNT: prdata = 32'(segment_count_q);
			default:                     prdata = '0;
		endcase
	end

	// advance the whole pipeline unless the held output is stalled
	assign en        = !(vert_valid && vert_stall);
	assign idx_stall = !en;

	svg_divider u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (idx_valid),
		.idx     (idx_data),
		.rings   (ring_count_q),
		.segs    (segment_count_q),
		.vld_out (div_vld),
		.polar   (polar),
		.azim    (azim),
		.side    (div_side)
	);

	svg_sincos u_polar (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (div_vld),
		.phase   (polar),
		.vld_out (p_vld),
		.trig    (p_trig)
	);

	svg_sincos u_azim (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.vld_in  (div_vld),
		.phase   (azim),
		.vld_out (a_vld),
		.trig    (a_trig)
	);

	// carry texture coordinates and the index-valid flag alongside the trig pipelines
	always_ff @(posedge clk) begin
		if (en) begin
			side_q[0] <= div_side;
			for (int i = 1; i < svg_pkg::SC_STAGES; i++) begin
				side_q[i] <= side_q[i-1];
			end
		end
	end

	svg_vertex u_vertex (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.vld_in     (p_vld && a_vld),
		.polar_trig (p_trig),
		.azim_trig  (a_trig),
		.side       (side_q[svg_pkg::SC_STAGES-1]),
		.vld_out    (vert_valid),
		.vert       (vert_data)
	);

	`SVG_ASSERT(a_stall_blocks_input, clk, arst_n, vert_valid && vert_stall, idx_stall)
	`SVG_ASSERT(a_seg_count_range, clk, arst_n, 1'b1, (segment_count_q >= 9'd3) && (segment_count_q <= 9'd256))
	`SVG_ASSERT_NEXT(a_seg_count_write, clk, arst_n, cfg_wr && paddr[2] && (seg_w >= 9'd3) && (seg_w <= 9'd256), segment_count_q == $past(seg_w))

endmodule

### tb/sv/tb_sphere_vertex_generator_core.sv
// ----------------------------------------------------------------------------
// Sphere vertex generator core testbench
// Drives ring/segment index pairs through several ring and segment count
// settings, predicts each vertex in fixed point (two directed rows give theirs)
// and compares each output transaction in order, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_sphere_vertex_generator_core;

	localparam longint unsigned ONE_Q30  = 64'd1 << 30;
	localparam longint unsigned HPI_Q30  = 64'd1686629713;
	localparam int              SETTLE   = 40;

	logic                         clk;
	logic                         arst_n;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [svg_pkg::ADDR_W-1:0]   paddr;
	logic [31:0]                  pwdata;
	logic [31:0]                  prdata;
	logic                         pready;
	logic                         idx_valid;
	logic                         idx_stall;
	svg_pkg::idx_t                idx_data;
	logic                         vert_valid;
	logic                         vert_stall;
	svg_pkg::vert_t               vert_data;

	typedef struct {
		logic [7:0]     ring;
		logic [7:0]     seg;
		bit             typed;
		svg_pkg::vert_t want;
	} vec_row_t;

	svg_pkg::vert_t vertex_expect_q[$];
	int             mismatch_count;
	logic [7:0]     rings_cfg;
	logic [8:0]     segs_cfg;
	bit             idle_on;
	int             stall_left;

	sphere_vertex_generator_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.idx_valid  (idx_valid),
		.idx_stall  (idx_stall),
		.idx_data   (idx_data),
		.vert_valid (vert_valid),
		.vert_stall (vert_stall),
		.vert_data  (vert_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint unsigned horner(longint unsigned t, longint unsigned x2,
		longint unsigned d);
		longint unsigned p;
		p = ((x2 * t) >> 30) / d;
		return (p > ONE_Q30) ? 64'd0 : ONE_Q30 - p;
	endfunction

	task automatic sin_cos(input logic [31:0] phase, output longint s_o, output longint c_o);
		logic [1:0]      quad;
		longint unsigned x, x2, t, s, c, p;
		quad = phase[31:30];
		x  = ({34'd0, phase[29:0]} * HPI_Q30) >> 30;
		x2 = (x * x) >> 30;
		t = horner(ONE_Q30, x2, 110);
		t = horner(t, x2, 72);
		t = horner(t, x2, 42);
		t = horner(t, x2, 20);
		t = horner(t, x2, 6);
		s = (x * t) >> 30;
		t = horner(ONE_Q30, x2, 132);
		t = horner(t, x2, 90);
		t = horner(t, x2, 56);
		t = horner(t, x2, 30);
		t = horner(t, x2, 12);
		p = ((x2 * t) >> 30) / 2;
		c = (p > ONE_Q30) ? 64'd0 : ONE_Q30 - p;
		case (quad)
			2'd0: begin s_o = s;  c_o = c;  end
			2'd1: begin s_o = c;  c_o = -longint'(s); end
			2'd2: begin s_o = -longint'(s); c_o = -longint'(c); end
			default: begin s_o = -longint'(c); c_o = s; end
		endcase
	endtask

	// halve a signed Q30 value into Q15, round half away from zero
	function automatic logic [15:0] q30_half(longint v);
		longint unsigned m;
		m = (v < 0) ? longint'(-v) : v;
		m = (m + (64'd1 << 15)) >> 16;
		if (m > 16384)
			m = 16384;
		return (v < 0) ? 16'(-m) : 16'(m);
	endfunction

	function automatic logic [15:0] q30_mul_half(longint a, longint b);
		longint unsigned ma, mb, m;
		ma = (a < 0) ? longint'(-a) : a;
		mb = (b < 0) ? longint'(-b) : b;
		m  = (ma * mb) >> 30;
		return q30_half(((a < 0) != (b < 0)) ? -longint'(m) : longint'(m));
	endfunction

	task automatic predict_vertex(input svg_pkg::idx_t in_pair, output svg_pkg::vert_t v);
		longint unsigned ring, seg, rings, segs;
		logic [31:0]     polar, azim;
		longint          sp, cp, sa, ca;
		ring  = in_pair.ring_index;
		seg   = in_pair.segment_index;
		rings = rings_cfg;
		segs  = segs_cfg;
		v.index_valid = 1'b1;
		if (ring > rings) begin
			ring = rings;
			v.index_valid = 1'b0;
		end
		if (seg >= segs) begin
			seg = segs - 1;
			v.index_valid = 1'b0;
		end
		polar = 32'((ring << 31) / rings);
		azim  = 32'((seg << 32) / segs);
		sin_cos(polar, sp, cp);
		sin_cos(azim, sa, ca);
		v.pos_x = q30_mul_half(sp, ca);
		v.pos_y = q30_half(cp);
		v.pos_z = q30_mul_half(sp, sa);
		v.tex_u = 17'((seg * 65536 + segs / 2) / segs);
		v.tex_v = 17'((ring * 65536 + rings / 2) / rings);
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (!idle_on || r < 60)
			return 0;
		if (r < 95)
			return $urandom_range(1, 3);
		return $urandom_range(10, 30);
	endfunction

	task automatic reg_write(input logic [svg_pkg::ADDR_W-1:0] addr, input logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// apply the same clamping the block does on a count write
	task automatic set_counts(input logic [31:0] rw, input logic [31:0] sw);
		logic [8:0] s;
		reg_write(svg_pkg::ADDR_W'(svg_pkg::ADDR_RING_COUNT) << 2, rw);
		reg_write(svg_pkg::ADDR_W'(svg_pkg::ADDR_SEGMENT_COUNT) << 2, sw);
		rings_cfg = (rw[7:0] < svg_pkg::MIN_RINGS) ? 8'(svg_pkg::MIN_RINGS) : rw[7:0];
		s = sw[8:0];
		if (s < svg_pkg::MIN_SEGMENTS)
			s = 9'(svg_pkg::MIN_SEGMENTS);
		if (s > svg_pkg::MAX_SEGMENTS)
			s = 9'(svg_pkg::MAX_SEGMENTS);
		segs_cfg = s;
	endtask

	task automatic send_pair(input svg_pkg::idx_t pair, input bit typed,
		input svg_pkg::vert_t want);
		svg_pkg::vert_t v;
		int             gap;
		gap = pick_gap();
		if (gap > 0) begin
			idx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		if (typed)
			v = want;
		else
			predict_vertex(pair, v);
		vertex_expect_q.push_back(v);
		idx_valid <= 1'b1;
		idx_data  <= pair;
		do
			@(posedge clk);
		while (idx_stall);
	endtask

	task automatic drain();
		idx_valid <= 1'b0;
		wait (vertex_expect_q.size() == 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (stall_left > 0) begin
			vert_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			vert_stall <= 1'b0;
			stall_left <= pick_gap();
		end
	end

	always @(posedge clk) begin
		svg_pkg::vert_t want;
		if (arst_n && vert_valid && !vert_stall) begin
			if (vertex_expect_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected vertex %p", vert_data);
			end else begin
				want = vertex_expect_q.pop_front();
				if (vert_data.pos_x !== want.pos_x || vert_data.pos_y !== want.pos_y ||
					vert_data.pos_z !== want.pos_z || vert_data.tex_u !== want.tex_u ||
					vert_data.tex_v !== want.tex_v ||
					vert_data.index_valid !== want.index_valid) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("vertex mismatch: expected %p got %p", want, vert_data);
				end
			end
		end
	end

	initial begin
		#5_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		vec_row_t       rows[$];
		vec_row_t       row;
		svg_pkg::vert_t none;
		svg_pkg::idx_t  pair;
		logic [31:0]    cfg_rings[8];
		logic [31:0]    cfg_segs[8];
		int             n;

		cfg_rings = '{32'd16, 32'd2, 32'd255, 32'd0, 32'd1, 32'h1FF, 32'd7, 32'd0};
		cfg_segs  = '{32'd32, 32'd3, 32'd256, 32'd0, 32'd2, 32'h1FF, 32'd5, 32'd300};
		cfg_rings[7] = $urandom_range(2, 255);
		cfg_segs[7]  = $urandom_range(3, 256);

		none = '0;
		rows = '{
			'{8'd0,   8'd0,   1'b1, '{16'sd0, 16'sd16384, 16'sd0, 17'd0, 17'd0, 1'b1}},
			'{8'd16,  8'd0,   1'b1, '{16'sd0, -16'sd16384, 16'sd0, 17'd0, 17'd65536, 1'b1}},
			'{8'd8,   8'd0,   1'b0, none}, '{8'd8,   8'd8,   1'b0, none},
			'{8'd8,   8'd16,  1'b0, none}, '{8'd8,   8'd24,  1'b0, none},
			'{8'd4,   8'd31,  1'b0, none}, '{8'd12,  8'd5,   1'b0, none},
			'{8'd255, 8'd255, 1'b0, none}, '{8'd17,  8'd31,  1'b0, none},
			'{8'd16,  8'd32,  1'b0, none}, '{8'd0,   8'd255, 1'b0, none},
			'{8'd255, 8'd0,   1'b0, none}, '{8'd1,   8'd1,   1'b0, none},
			'{8'd15,  8'd31,  1'b0, none}, '{8'd170, 8'd85,  1'b0, none},
			'{8'd85,  8'd170, 1'b0, none}, '{8'd128, 8'd128, 1'b0, none}
		};

		arst_n     = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		idx_valid  = 1'b0;
		idx_data   = '0;
		vert_stall = 1'b0;
		stall_left = 0;
		idle_on    = 1'b0;
		mismatch_count = 0;
		rings_cfg  = svg_pkg::RING_COUNT_RESET;
		segs_cfg   = svg_pkg::SEGMENT_COUNT_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			row = rows[i];
			pair.ring_index    = row.ring;
			pair.segment_index = row.seg;
			send_pair(pair, row.typed, row.want);
		end
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			if (ph > 0)
				set_counts(cfg_rings[ph], cfg_segs[ph]);
			idle_on = (ph % 3 != 1);
			n = (ph == 0) ? 70 : 92;
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(0, 99) < 15) begin
					pair = svg_pkg::idx_t'(16'($urandom_range(0, 16'hFFFF)));
				end else begin
					pair.ring_index    = 8'($urandom_range(0, rings_cfg));
					pair.segment_index = 8'($urandom_range(0, segs_cfg - 1));
				end
				send_pair(pair, 1'b0, none);
			end
			drain();
		end

		if (mismatch_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
